// File: rtl/kfi_pkg.sv
`timescale 1ns / 1ps

package kfi_pkg;

  // Default table geometry.
  localparam int MAX_KEYS_DEF    = 64;
  localparam int MAX_COLUMNS_DEF = 16;

  // Q1.16 one and the number of quotient bits the serial divider produces.
  localparam logic [16:0] Q16_ONE   = 17'd65536;
  localparam int          DIV_STEPS = 48;
  localparam int          DIV_CNT_W = $clog2(DIV_STEPS);

  // Configuration port geometry.
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 7;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_KEY_COUNT    = 1'b0,
    REG_COLUMN_COUNT = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_t;

  // Input item.
  typedef struct packed {
    logic               cmd;
    logic [5:0]         key_index;
    logic [3:0]         column_index;
    logic signed [31:0] table_value;
    logic signed [31:0] query_time;
  } item_t;

  // Result item.
  typedef struct packed {
    logic [3:0]         out_column;
    logic signed [31:0] out_value;
    logic               last;
  } result_t;

  // Divider request and response.
  typedef struct packed {
    logic        start;
    logic [31:0] num;
    logic [31:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [16:0] frac;
  } div_resp_t;

  // Query sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SRCH_RD,
    ST_SRCH_CMP,
    ST_DIV,
    ST_COL_A,
    ST_COL_B,
    ST_COL_MUL,
    ST_COL_OUT
  } state_t;

  // How the columns of a query are formed.
  typedef enum logic [1:0] {
    MODE_ROW_N,
    MODE_ROW_PREV,
    MODE_BLEND
  } mode_t;

endpackage

// File: rtl/kfi_table.sv
`timescale 1ns / 1ps

module kfi_table
  import kfi_pkg::*;
#(
  parameter int DEPTH = MAX_KEYS_DEF * MAX_COLUMNS_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [AW-1:0]        waddr,
  input  logic signed [31:0]   wdata,
  input  logic                 re,
  input  logic [AW-1:0]        raddr,
  output logic signed [31:0]   rdata
);

  logic signed [31:0] mem [DEPTH];

  // Single write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/kfi_divider.sv
`timescale 1ns / 1ps

module kfi_divider
  import kfi_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  div_req_t  req,
  output div_resp_t resp
);

  logic                 running;
  logic                 done;
  logic [DIV_CNT_W-1:0] cnt;
  logic [31:0]          rem;
  logic [31:0]          den;
  logic [47:0]          dvd;
  logic [47:0]          quo;
  logic [32:0]          trial;
  logic                 fits;

  // One restoring step: shift in the next dividend bit and try the subtraction.
  assign trial = {rem, dvd[47]};
  assign fits  = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        running <= 1'b1;
      end else if (running && cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
        running <= 1'b0;
        done    <= 1'b1;
      end
    end
  end

  // Datapath: the dividend is the numerator scaled by 2^16.
  always_ff @(posedge clk) begin
    if (req.start) begin
      cnt <= '0;
      rem <= '0;
      den <= req.den;
      dvd <= {req.num, 16'd0};
      quo <= '0;
    end else if (running) begin
      cnt <= cnt + DIV_CNT_W'(1);
      rem <= fits ? 32'(trial - {1'b0, den}) : trial[31:0];
      dvd <= {dvd[46:0], 1'b0};
      quo <= {quo[46:0], fits};
    end
  end

  // The fraction saturates at one.
  assign resp.done = done;
  assign resp.frac = (quo > 48'(Q16_ONE)) ? Q16_ONE : quo[16:0];

endmodule

// File: rtl/kfi_blend.sv
`timescale 1ns / 1ps

module kfi_blend
  import kfi_pkg::*;
(
  input  logic               clk,
  input  logic               en,
  input  logic [16:0]        frac,
  input  logic signed [31:0] prev,
  input  logic signed [31:0] next,
  output logic signed [31:0] value
);

  logic signed [49:0] prod_prev;
  logic signed [49:0] prod_next;
  logic signed [49:0] sum;
  logic [16:0]        weight_prev;

  assign weight_prev = Q16_ONE - frac;

  // Both weighted terms are registered before the sum.
  always_ff @(posedge clk) begin
    if (en) begin
      prod_prev <= $signed({1'b0, weight_prev}) * prev;
      prod_next <= $signed({1'b0, frac}) * next;
    end
  end

  // Round half up, then floor by an arithmetic shift.
  assign sum   = prod_prev + prod_next + 50'sd32768;
  assign value = 32'(sum >>> 16);

endmodule

// File: rtl/keyframe_linear_interpolator_core.sv
`timescale 1ns / 1ps

// Keyframe linear interpolator. A load item (cmd 0) writes one Q16.16 entry
// of the keyframe table at the edge it is accepted. A query item (cmd 1)
// keeps busy high while it walks the key times through the single read port
// of the table, a read and a compare per key visited. When the chosen key is
// not the first and its time is above that of the key before it, the query
// then waits on a 48-step serial divider for the blend fraction (the 48 steps,
// then the hand-over of the fraction). Finally it produces one result per
// column in use, each through two table reads, the multiply and the sum.
// Busy stays high until the last column is out, so no new item is taken
// before then, and the last result is shown as busy falls.
// Each result is shown on result for exactly one cycle with result_valid
// high and cannot be held off, so the receiver must take it then. The table
// is not cleared after reset: every entry a query can reach must be loaded
// first. Configuration writes belong to times when no query is running.
module keyframe_linear_interpolator_core
  import kfi_pkg::*;
#(
  parameter int MAX_KEYS    = MAX_KEYS_DEF,
  parameter int MAX_COLUMNS = MAX_COLUMNS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  item_t                  item,
  output result_t                result,
  output logic                   result_valid,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int DEPTH = MAX_KEYS * MAX_COLUMNS;
  localparam int AW    = $clog2(DEPTH);
  localparam int KIW   = $clog2(MAX_KEYS);
  localparam int KCW   = $clog2(MAX_KEYS + 1);
  localparam int CIW   = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int CCW   = $clog2(MAX_COLUMNS + 1);

  state_t             state;
  state_t             state_next;
  logic [6:0]         key_count;
  logic [4:0]         column_count;
  logic [KCW-1:0]     keys_eff;
  logic [CCW-1:0]     cols_eff;
  logic [KCW-1:0]     keys;
  logic [CCW-1:0]     cols;
  logic signed [31:0] t;
  logic signed [31:0] prev_time;
  logic [KIW-1:0]     n;
  logic [KIW-1:0]     row_a;
  logic [CIW-1:0]     col;
  mode_t              mode;
  logic [16:0]        frac;
  logic signed [31:0] a_val;
  logic signed [31:0] rdata;
  logic signed [31:0] blend_value;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic               accept_query;
  logic               advance;
  logic               last_col;
  logic [32:0]        num_wide;
  logic [32:0]        den_wide;
  div_req_t           div_req;
  div_resp_t          div_resp;

  function automatic logic [AW-1:0] entry_addr(logic [KIW-1:0] row, logic [CIW-1:0] c);
    entry_addr = AW'(row) * AW'(MAX_COLUMNS) + AW'(c);
  endfunction

  assign busy         = state != ST_IDLE;
  assign accept_query = start && !busy && item.cmd == CMD_QUERY;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      key_count    <= 7'd1;
      column_count <= 5'd1;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_KEY_COUNT:    key_count    <= cfg_data;
        REG_COLUMN_COUNT: column_count <= 5'(cfg_data);
        default: ;
      endcase
    end
  end

  // Clamp the register values to the table geometry.
  always_comb begin
    if (key_count == '0) begin
      keys_eff = KCW'(1);
    end else if (int'(key_count) > MAX_KEYS) begin
      keys_eff = KCW'(MAX_KEYS);
    end else begin
      keys_eff = KCW'(key_count);
    end
    if (column_count == '0) begin
      cols_eff = CCW'(1);
    end else if (int'(column_count) > MAX_COLUMNS) begin
      cols_eff = CCW'(MAX_COLUMNS);
    end else begin
      cols_eff = CCW'(column_count);
    end
  end

  // Loads write the table at their transfer; queries never read then.
  assign wr_en   = start && !busy && item.cmd == CMD_LOAD
                   && int'(item.key_index) < MAX_KEYS
                   && int'(item.column_index) < MAX_COLUMNS;
  assign wr_addr = entry_addr(KIW'(item.key_index), CIW'(item.column_index));

  kfi_table #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_table (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (item.table_value),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  // Search and column conditions.
  assign advance  = (KCW'(n) + KCW'(1)) < keys && t > rdata;
  assign last_col = (CCW'(col) + CCW'(1)) == cols;
  assign row_a    = (mode == MODE_ROW_N) ? n : n - KIW'(1);
  assign num_wide = {t[31], t} - {prev_time[31], prev_time};
  assign den_wide = {rdata[31], rdata} - {prev_time[31], prev_time};

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept_query) begin
          state_next = ST_SRCH_RD;
        end
      end
      ST_SRCH_RD: state_next = ST_SRCH_CMP;
      ST_SRCH_CMP: begin
        if (advance) begin
          state_next = ST_SRCH_RD;
        end else if (n == '0 || rdata <= prev_time) begin
          state_next = ST_COL_A;
        end else begin
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_resp.done) begin
          state_next = ST_COL_A;
        end
      end
      ST_COL_A:   state_next = ST_COL_B;
      ST_COL_B:   state_next = ST_COL_MUL;
      ST_COL_MUL: state_next = ST_COL_OUT;
      ST_COL_OUT: state_next = last_col ? ST_IDLE : ST_COL_A;
      default:    state_next = ST_IDLE;
    endcase
  end

  // Table reads and divider start.
  always_comb begin
    rd_en         = 1'b0;
    rd_addr       = entry_addr(n, '0);
    div_req.start = 1'b0;
    div_req.num   = num_wide[31:0];
    div_req.den   = den_wide[31:0];
    case (state)
      ST_SRCH_RD: begin
        rd_en   = 1'b1;
        rd_addr = entry_addr(n, '0);
      end
      ST_SRCH_CMP: begin
        div_req.start = !advance && n != '0 && rdata > prev_time;
      end
      ST_COL_A: begin
        rd_en   = 1'b1;
        rd_addr = entry_addr(row_a, col);
      end
      ST_COL_B: begin
        rd_en   = 1'b1;
        rd_addr = entry_addr(n, col);
      end
      default: ;
    endcase
  end

  kfi_divider u_divider (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .resp (div_resp)
  );

  kfi_blend u_blend (
    .clk   (clk),
    .en    (state == ST_COL_MUL),
    .frac  (frac),
    .prev  (a_val),
    .next  (rdata),
    .value (blend_value)
  );

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= state == ST_COL_OUT;
    end
  end

  // Query datapath.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept_query) begin
          t    <= item.query_time;
          keys <= keys_eff;
          cols <= cols_eff;
          n    <= '0;
          col  <= '0;
        end
      end
      ST_SRCH_CMP: begin
        if (advance) begin
          prev_time <= rdata;
          n         <= n + KIW'(1);
        end else if (n == '0) begin
          mode <= MODE_ROW_N;
        end else if (rdata == prev_time) begin
          mode <= MODE_ROW_PREV;
        end else begin
          // Decreasing key times blend with a zero fraction.
          mode <= MODE_BLEND;
          frac <= '0;
        end
      end
      ST_DIV: begin
        if (div_resp.done) begin
          frac <= div_resp.frac;
        end
      end
      ST_COL_B: a_val <= rdata;
      ST_COL_OUT: begin
        result.out_column <= 4'(col);
        result.out_value  <= (mode == MODE_BLEND) ? blend_value : a_val;
        result.last       <= last_col;
        col               <= col + CIW'(1);
      end
      default: ;
    endcase
  end

  // A result strobe follows only the output step of a column.
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(state == ST_COL_OUT))
    else $error("result strobe without a column output step");

  // The final result of a query leaves the sequencer idle.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result.last |-> state == ST_IDLE)
    else $error("sequencer still busy after the last column");

  // The divider only finishes while the sequencer waits for it.
  assert property (@(posedge clk) disable iff (rst)
    div_resp.done |-> state == ST_DIV)
    else $error("divider finished outside its wait state");

  // The column counter stays within the columns in use.
  assert property (@(posedge clk) disable iff (rst)
    state == ST_COL_A |-> CCW'(col) < cols)
    else $error("column counter beyond the columns in use");

endmodule

// File: dv/tb_keyframe_linear_interpolator_core.sv
`timescale 1ns / 1ps

module tb_keyframe_linear_interpolator_core
  import kfi_pkg::*;
();

  localparam int     SETTLE_CYCLES = 8;
  localparam int     DRAIN_LIMIT   = 5000;
  localparam int     CYCLE_LIMIT   = 600000;
  localparam int     NUM_DIRECTED  = 22;
  localparam longint ONE_Q16       = 65536;
  localparam longint Q16_MAX       = 64'sd2147483647;
  localparam longint Q16_MIN       = -64'sd2147483648;
  localparam logic [31:0] Q16_MAX_BITS = 32'h7FFF_FFFF;
  localparam logic [31:0] Q16_MIN_BITS = 32'h8000_0000;

  typedef enum logic [1:0] {
    STEP_LOAD,
    STEP_QUERY,
    STEP_SET
  } step_kind_t;

  // One row of the directed table. For a load, arg_a/arg_b are key and column;
  // for a setting they are the raw key_count and column_count data.
  typedef struct packed {
    step_kind_t  kind;
    logic [6:0]  arg_a;
    logic [6:0]  arg_b;
    logic [31:0] value;
    logic        typed;
    logic [31:0] want;
  } directed_step_t;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    start = 1'b0;
  logic    busy;
  item_t   item = '0;
  result_t result;
  logic    result_valid;
  logic    cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  // Shadow copy of the keyframe table and the configuration registers.
  logic signed [31:0] kf_table [MAX_KEYS_DEF][MAX_COLUMNS_DEF];
  bit                 table_loaded [MAX_KEYS_DEF][MAX_COLUMNS_DEF];
  logic [6:0]         key_reg = 7'd1;
  logic [4:0]         col_reg = 5'd1;

  result_t        expected_columns [$];
  directed_step_t directed_steps [NUM_DIRECTED];

  bit no_idle = 1'b0;
  int failures = 0;
  int loads_sent = 0;
  int queries_sent = 0;
  int results_seen = 0;
  int settings_applied = 0;
  int cycle_count = 0;

  keyframe_linear_interpolator_core DUT (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .item        (item),
    .result      (result),
    .result_valid(result_valid),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Hard limit on the run length.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.", cycle_count,
               expected_columns.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Every strobed result is compared with the oldest expected column.
  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && result_valid) begin
      results_seen++;
      if (expected_columns.size() == 0) begin
        $error("Unexpected result: out_column %0d out_value %0d last %0d",
               result.out_column, result.out_value, result.last);
        failures++;
      end else begin
        want = expected_columns.pop_front();
        if (result.out_column !== want.out_column) begin
          $error("out_column mismatch: expected %0d, actual %0d", want.out_column,
                 result.out_column);
          failures++;
        end
        if (result.out_value !== want.out_value) begin
          $error("out_value mismatch: expected %0d, actual %0d", want.out_value,
                 result.out_value);
          failures++;
        end
        if (result.last !== want.last) begin
          $error("last mismatch: expected %0d, actual %0d", want.last, result.last);
          failures++;
        end
      end
    end
  end

  // Register values as the block uses them, after clamping.
  function automatic int active_keys();
    if (key_reg == 0) return 1;
    if (key_reg > MAX_KEYS_DEF) return MAX_KEYS_DEF;
    return int'(key_reg);
  endfunction

  function automatic int active_cols();
    if (col_reg == 0) return 1;
    if (col_reg > MAX_COLUMNS_DEF) return MAX_COLUMNS_DEF;
    return int'(col_reg);
  endfunction

  function automatic logic [31:0] clamp_q16(input longint x);
    if (x > Q16_MAX) return Q16_MAX_BITS;
    if (x < Q16_MIN) return Q16_MIN_BITS;
    return x[31:0];
  endfunction

  // Append one expected column at the tail of the queue.
  function automatic void queue_expected(input result_t r);
    expected_columns = {expected_columns, r};
  endfunction

  // Search the key times, pick the blend fraction and queue one expected
  // column per column in use.
  function automatic void interpolate_row(input logic signed [31:0] qt);
    int     keys;
    int     cols;
    int     n;
    longint tp;
    longint tn;
    longint num;
    longint den;
    longint frac;
    longint acc;
    mode_t  mode;
    result_t r;
    keys = active_keys();
    cols = active_cols();
    n = 0;
    while (n < keys - 1 && qt > kf_table[n][0]) n++;
    frac = 0;
    mode = MODE_ROW_N;
    if (n != 0) begin
      tp = kf_table[n-1][0];
      tn = kf_table[n][0];
      if (tp == tn) begin
        mode = MODE_ROW_PREV;
      end else begin
        mode = MODE_BLEND;
        // Decreasing key times leave the fraction at zero.
        if (tn > tp) begin
          num = longint'(qt) - tp;
          den = tn - tp;
          frac = (num <<< 16) / den;
          if (frac > ONE_Q16) frac = ONE_Q16;
        end
      end
    end
    for (int c = 0; c < cols; c++) begin
      case (mode)
        MODE_ROW_N:    acc = kf_table[n][c];
        MODE_ROW_PREV: acc = kf_table[n-1][c];
        default: begin
          acc = ((ONE_Q16 - frac) * longint'(kf_table[n-1][c])
                 + frac * longint'(kf_table[n][c]) + 32768) >>> 16;
        end
      endcase
      r.out_column = 4'(c);
      r.out_value  = acc[31:0];
      r.last       = (c == cols - 1);
      queue_expected(r);
    end
  endfunction

  // Table values lean toward the extremes now and then.
  function automatic logic [31:0] random_entry();
    case ($urandom_range(0, 7))
      0:       return Q16_MIN_BITS;
      1:       return Q16_MAX_BITS;
      default: return $urandom;
    endcase
  endfunction

  // Fields a command does not use still carry random bits.
  function automatic item_t load_item(input int k, input int c, input logic [31:0] v);
    item_t it;
    it.cmd          = CMD_LOAD;
    it.key_index    = 6'(k);
    it.column_index = 4'(c);
    it.table_value  = v;
    it.query_time   = $urandom;
    return it;
  endfunction

  function automatic item_t query_item(input logic [31:0] t);
    item_t it;
    it.cmd          = CMD_QUERY;
    it.key_index    = 6'($urandom);
    it.column_index = 4'($urandom);
    it.table_value  = $urandom;
    it.query_time   = t;
    return it;
  endfunction

  // Query times mostly fall inside the span of the keys in use.
  function automatic logic [31:0] pick_query_time(input int keys);
    longint lo;
    longint hi;
    longint span;
    longint off;
    int     k;
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return Q16_MIN_BITS;
      2: return Q16_MAX_BITS;
      3: begin
        k = $urandom_range(0, keys - 1);
        return kf_table[k][0];
      end
      default: begin
        lo = kf_table[0][0];
        hi = kf_table[keys-1][0];
        if (hi < lo) begin
          span = lo;
          lo = hi;
          hi = span;
        end
        lo -= ONE_Q16;
        hi += ONE_Q16;
        span = hi - lo;
        off = longint'({$urandom, $urandom} >> 1) % (span + 1);
        return clamp_q16(lo + off);
      end
    endcase
  endfunction

  // Offer one item after a random gap and hold it until the transfer.
  task automatic send_item(input item_t it, input bit typed = 1'b0,
                           input logic [31:0] want = '0);
    int      gap;
    result_t fixed;
    gap = no_idle ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    item  <= it;
    do @(posedge clk); while (busy);
    if (it.cmd == CMD_LOAD) begin
      kf_table[it.key_index][it.column_index] = it.table_value;
      table_loaded[it.key_index][it.column_index] = 1'b1;
      loads_sent++;
    end else begin
      queries_sent++;
      if (typed) begin
        fixed.out_column = '0;
        fixed.out_value  = want;
        fixed.last       = 1'b1;
        queue_expected(fixed);
      end else begin
        interpolate_row(it.query_time);
      end
    end
  endtask

  // Wait until the block has delivered everything and gone idle.
  task automatic settle();
    start <= 1'b0;
    while (expected_columns.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Write both registers on consecutive cycles.
  task automatic apply_setting(input logic [6:0] keys_data, input logic [6:0] cols_data);
    cfg_write <= 1'b1;
    cfg_index <= REG_KEY_COUNT;
    cfg_data  <= keys_data;
    @(posedge clk);
    cfg_index <= REG_COLUMN_COUNT;
    cfg_data  <= cols_data;
    @(posedge clk);
    cfg_write <= 1'b0;
    key_reg = keys_data;
    col_reg = cols_data[4:0];
    settings_applied++;
  endtask

  // One setting: fresh key times, fill of any unloaded entry in use, then a
  // mix of queries and stray loads.
  task automatic run_phase(input logic [6:0] keys_data, input logic [6:0] cols_data,
                           input int batch, input bit steady);
    int     keys;
    int     cols;
    int     pick;
    longint t;
    longint step;
    settle();
    apply_setting(keys_data, cols_data);
    no_idle = steady;
    keys = active_keys();
    cols = active_cols();
    pick = $urandom_range(0, 5);
    t = (pick == 0) ? Q16_MIN : longint'($urandom_range(0, 1 << 25)) - (1 << 24);

    // Key times mostly rise, with the odd repeat or drop.
    for (int k = 0; k < keys; k++) begin
      send_item(load_item(k, 0, clamp_q16(t)));
      case ($urandom_range(0, 15))
        0:       step = 0;
        1:       step = -longint'($urandom_range(1, 1 << 20));
        default: step = (pick == 0) ? longint'($urandom_range(1, 1 << 30))
                                    : longint'($urandom_range(1, 1 << 20));
      endcase
      t += step;
    end

    for (int k = 0; k < keys; k++) begin
      for (int c = 1; c < cols; c++) begin
        if (!table_loaded[k][c]) send_item(load_item(k, c, random_entry()));
      end
    end

    for (int i = 0; i < batch; i++) begin
      if ($urandom_range(0, 3) == 0) begin
        if ($urandom_range(0, 1) == 1) begin
          send_item(load_item($urandom_range(0, keys - 1), $urandom_range(0, cols - 1),
                              random_entry()));
        end else begin
          send_item(load_item($urandom_range(0, MAX_KEYS_DEF - 1),
                              $urandom_range(0, MAX_COLUMNS_DEF - 1), random_entry()));
        end
      end else begin
        send_item(query_item(pick_query_time(keys)));
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin : stimulus
    int wait_cycles;
    foreach (kf_table[k, c]) begin
      kf_table[k][c] = '0;
      table_loaded[k][c] = 1'b0;
    end

    // Directed table: single key and full-range times, blend ends, a query
    // past the last key, equal key times, decreasing key times and
    // out-of-range register values.
    directed_steps = '{
      '{STEP_LOAD,  7'd0, 7'd0, Q16_MIN_BITS,  1'b0, 32'h0},
      '{STEP_QUERY, 7'd0, 7'd0, 32'h0,         1'b1, Q16_MIN_BITS},
      '{STEP_LOAD,  7'd0, 7'd0, Q16_MAX_BITS,  1'b0, 32'h0},
      '{STEP_QUERY, 7'd0, 7'd0, Q16_MIN_BITS,  1'b1, Q16_MAX_BITS},
      '{STEP_SET,   7'd2, 7'd1, 32'h0,         1'b0, 32'h0},
      '{STEP_LOAD,  7'd1, 7'd0, Q16_MAX_BITS,  1'b0, 32'h0},
      '{STEP_LOAD,  7'd0, 7'd0, Q16_MIN_BITS,  1'b0, 32'h0},
      '{STEP_QUERY, 7'd0, 7'd0, Q16_MIN_BITS,  1'b1, Q16_MIN_BITS},
      '{STEP_QUERY, 7'd0, 7'd0, Q16_MAX_BITS,  1'b1, Q16_MAX_BITS},
      '{STEP_QUERY, 7'd0, 7'd0, 32'h0,         1'b0, 32'h0},
      '{STEP_LOAD,  7'd0, 7'd0, 32'h0,         1'b0, 32'h0},
      '{STEP_LOAD,  7'd1, 7'd0, 32'h0001_0000, 1'b0, 32'h0},
      '{STEP_QUERY, 7'd0, 7'd0, Q16_MAX_BITS,  1'b1, 32'h0001_0000},
      '{STEP_QUERY, 7'd0, 7'd0, 32'h0000_8000, 1'b0, 32'h0},
      '{STEP_LOAD,  7'd1, 7'd0, 32'h0,         1'b0, 32'h0},
      '{STEP_QUERY, 7'd0, 7'd0, 32'h0005_0000, 1'b1, 32'h0},
      '{STEP_SET,   7'd3, 7'd1, 32'h0,         1'b0, 32'h0},
      '{STEP_LOAD,  7'd1, 7'd0, 32'h000A_0000, 1'b0, 32'h0},
      '{STEP_LOAD,  7'd2, 7'd0, 32'h0005_0000, 1'b0, 32'h0},
      '{STEP_QUERY, 7'd0, 7'd0, 32'h0014_0000, 1'b1, 32'h000A_0000},
      '{STEP_SET,   7'd0, 7'd0, 32'h0,         1'b0, 32'h0},
      '{STEP_QUERY, 7'd0, 7'd0, Q16_MAX_BITS,  1'b1, 32'h0}
    };

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < NUM_DIRECTED; i++) begin
      case (directed_steps[i].kind)
        STEP_LOAD: begin
          send_item(load_item(int'(directed_steps[i].arg_a), int'(directed_steps[i].arg_b),
                              directed_steps[i].value));
        end
        STEP_QUERY: begin
          send_item(query_item(directed_steps[i].value), directed_steps[i].typed,
                    directed_steps[i].want);
        end
        default: begin
          settle();
          apply_setting(directed_steps[i].arg_a, directed_steps[i].arg_b);
        end
      endcase
    end

    // Random phases: widest row, most keys, a clamped column count with no gaps,
    // small random geometries, a masked column count, then a single key and column.
    run_phase(7'd2, 7'd16, 20, 1'b0);
    run_phase(7'd127, 7'd1, 14, 1'b0);
    run_phase(7'd3, 7'd31, 14, 1'b1);
    repeat (5) begin
      run_phase(7'($urandom_range(1, 8)), 7'($urandom_range(1, 6)), 8,
                $urandom_range(0, 3) == 0);
    end
    run_phase(7'd2, 7'd127, 10, 1'b0);
    run_phase(7'd1, 7'd1, 8, 1'b0);

    // Drain the remaining results, then give the block time to misbehave.
    start <= 1'b0;
    wait_cycles = 0;
    while (expected_columns.size() != 0 && wait_cycles < DRAIN_LIMIT) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (20) @(posedge clk);
    if (expected_columns.size() != 0) begin
      $error("%0d expected results never arrived", expected_columns.size());
      failures++;
    end

    $display("Sent %0d loads and %0d queries across %0d register settings.", loads_sent,
             queries_sent, settings_applied);
    $display("Checked %0d column results; %0d mismatches.", results_seen, failures);
    if (failures == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
